// ===== hdl/tlr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlr_pkg;

    // Fixed field widths of the item channels and the configuration port.
    localparam int ROW_W       = 10;
    localparam int DIM_W       = 3;
    localparam int SAMPLE_W    = 32;
    localparam int LEN_W       = 11;
    localparam int RATIO_W     = 26;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 26;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 26'd65536;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_RATIO  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAREST_MODE = 2'd2;

    // Command codes.
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_RESAMPLE = 1'b1;

    typedef struct packed {
        logic                       command;
        logic [ROW_W-1:0]           row_index;
        logic [DIM_W-1:0]           dim_index;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result_value;
        logic                       index_clamped;
    } t_out_item;

    // How a resample gets its value.
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_NEAREST,
        KIND_LINEAR
    } t_kind;

    // Memory port sequencer of a linear resample.
    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } t_phase;

endpackage

`default_nettype wire

// ===== hdl/tlr_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tlr_in_if import tlr_pkg::*; ();

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== hdl/tlr_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tlr_out_if import tlr_pkg::*; ();

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== hdl/trajectory_linear_resampler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Width  Contents
// i_in      in         46     command, row_index, dim_index, sample_value
// o_out     out        33     result_value, index_clamped
// i_cfg_*   in         29     write enable, register index, write data
//
// A load takes one write of the single memory port, a nearest resample one read and a
// linear resample two reads (floor row, then ceiling row); that port sets the rate. A
// result then passes the token stage, stages B and C and the result queue.
// Reset clears the pipeline valids and the result queue and sets the configuration
// registers to their reset values; the trajectory store is not cleared. A stalled output
// fills a four-entry result queue; no resample is issued while four results are in flight.

module trajectory_linear_resampler_unit import tlr_pkg::*; #(
    parameter int MAX_STEPS = 1024,
    parameter int MAX_DIMS  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    tlr_in_if.sink                 i_in,
    tlr_out_if.source              o_out
);

    localparam int RW    = $clog2(MAX_STEPS);
    localparam int DEPTH = MAX_STEPS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int POS_W = ROW_W + RATIO_W;
    localparam int FL_W  = POS_W - FRAC_BITS;
    localparam int DF_W  = SAMPLE_W + 1;
    localparam int PW    = DF_W + FRAC_BITS + 1;
    localparam int SW    = PW + 1;
    localparam int FD    = 4;
    localparam int FP_W  = $clog2(FD);
    localparam int FC_W  = FP_W + 1;

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Configuration. The length register is kept as the clamped last row,
    // since that is all the datapath needs.
    // ------------------------------------------------------------------
    logic [RW-1:0]      r_last;
    logic [RATIO_W-1:0] r_ratio;
    logic               r_nearest;
    logic [31:0]        cfg_len;
    logic [31:0]        cfg_len_eff;

    always_comb begin
        cfg_len = 32'(i_cfg_data[LEN_W-1:0]);
        if (cfg_len == 32'd0) begin
            cfg_len_eff = 32'd1;
        end else if (cfg_len > 32'(MAX_STEPS)) begin
            cfg_len_eff = 32'(MAX_STEPS);
        end else begin
            cfg_len_eff = cfg_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_ratio   <= RATIO_RESET;
            r_nearest <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INPUT_LENGTH: r_last    <= RW'(cfg_len_eff - 32'd1);
                CFG_INDEX_RATIO:  r_ratio   <= i_cfg_data[RATIO_W-1:0];
                CFG_NEAREST_MODE: r_nearest <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the accepted item and its position, row times ratio.
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    logic               r_s1_cmd;
    logic [ROW_W-1:0]   r_s1_row;
    logic [DIM_W-1:0]   r_s1_dim;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic [POS_W-1:0]   r_s1_pos;
    logic               s2_take;
    logic               in_xfer;

    assign i_in.ready = !r_s1_valid || s2_take;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd    <= i_in.data.command;
            r_s1_row    <= i_in.data.row_index;
            r_s1_dim    <= i_in.data.dim_index;
            r_s1_sample <= i_in.data.sample_value;
            r_s1_pos    <= POS_W'(i_in.data.row_index) * POS_W'(r_ratio);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 to 2: floor and ceiling rows, clamping and store addresses.
    // ------------------------------------------------------------------
    logic [FL_W-1:0]      s1_floor;
    logic [FRAC_BITS-1:0] s1_frac_raw;
    logic [FRAC_BITS-1:0] s1_frac;
    logic                 s1_clamp;
    logic [RW-1:0]        s1_lo_row;
    logic [RW-1:0]        s1_hi_row;
    logic                 s1_dim_ok;
    logic                 s1_row_ok;
    logic [31:0]          s1_lo_base;
    logic [AW-1:0]        s1_addr_lo;
    logic [AW-1:0]        s1_addr_hi;
    t_kind                s1_kind;

    always_comb begin
        s1_floor    = r_s1_pos[POS_W-1:FRAC_BITS];
        s1_frac_raw = r_s1_pos[FRAC_BITS-1:0];
        s1_clamp    = POS_W'(s1_floor) > POS_W'(r_last);
        s1_lo_row   = s1_clamp ? r_last : RW'(s1_floor);
        s1_frac     = s1_clamp ? '0 : s1_frac_raw;
        if ((s1_frac != '0) && (s1_lo_row != r_last)) begin
            s1_hi_row = s1_lo_row + RW'(1);
        end else begin
            s1_hi_row = s1_lo_row;
        end
        s1_dim_ok  = 32'(r_s1_dim) < 32'(MAX_DIMS);
        s1_row_ok  = 32'(r_s1_row) < 32'(MAX_STEPS);
        // A load addresses its own row, a resample its floor row.
        s1_lo_base = (r_s1_cmd == CMD_LOAD) ? 32'(r_s1_row) : 32'(s1_lo_row);
        s1_addr_lo = AW'(s1_lo_base * 32'(MAX_DIMS) + 32'(r_s1_dim));
        s1_addr_hi = AW'(32'(s1_hi_row) * 32'(MAX_DIMS) + 32'(r_s1_dim));
        if (!s1_dim_ok) begin
            s1_kind = KIND_ZERO;
        end else if (r_nearest) begin
            s1_kind = KIND_NEAREST;
        end else begin
            s1_kind = KIND_LINEAR;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: owns the memory port until its accesses are done.
    // ------------------------------------------------------------------
    logic                 r_s2_valid;
    logic                 r_s2_cmd;
    t_kind                r_s2_kind;
    logic                 r_s2_load_ok;
    logic [AW-1:0]        r_s2_addr_lo;
    logic [AW-1:0]        r_s2_addr_hi;
    logic [SAMPLE_W-1:0]  r_s2_sample;
    logic [FRAC_BITS-1:0] r_s2_frac;
    logic                 r_s2_clamp;
    t_phase               r_phase;
    t_phase               n_phase;
    logic                 s2_done;
    logic                 credit_ok;
    logic                 tok_issue;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_addr;
    logic [SAMPLE_W-1:0]  ram_rdata;
    logic [FC_W-1:0]      r_inflight;
    logic                 is_linear;

    assign s2_take   = !r_s2_valid || s2_done;
    assign credit_ok = r_inflight < FC_W'(FD);
    assign is_linear = r_s2_valid && (r_s2_cmd == CMD_RESAMPLE) && (r_s2_kind == KIND_LINEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_phase    <= PH_FIRST;
        end else begin
            if (s2_take) begin
                r_s2_valid <= r_s1_valid;
            end
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s2_take) begin
            r_s2_cmd     <= r_s1_cmd;
            r_s2_kind    <= s1_kind;
            r_s2_load_ok <= s1_row_ok && s1_dim_ok;
            r_s2_addr_lo <= s1_addr_lo;
            r_s2_addr_hi <= s1_addr_hi;
            r_s2_sample  <= r_s1_sample;
            r_s2_frac    <= s1_frac;
            r_s2_clamp   <= s1_clamp;
        end
    end

    // Next state: a linear resample reads its floor row, then its ceiling row.
    always_comb begin
        n_phase = r_phase;
        if (is_linear) begin
            unique case (r_phase)
                PH_FIRST:  n_phase = PH_SECOND;
                PH_SECOND: if (credit_ok) n_phase = PH_FIRST;
                default:   n_phase = PH_FIRST;
            endcase
        end
    end

    // Port control. The last access of a resample waits for room in the result queue.
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_s2_addr_lo;
        s2_done   = 1'b0;
        tok_issue = 1'b0;
        if (r_s2_valid) begin
            if (r_s2_cmd == CMD_LOAD) begin
                ram_we  = r_s2_load_ok;
                s2_done = 1'b1;
            end else begin
                case (r_s2_kind)
                    KIND_ZERO: begin
                        s2_done = credit_ok;
                    end
                    KIND_NEAREST: begin
                        ram_re  = credit_ok;
                        s2_done = credit_ok;
                    end
                    KIND_LINEAR: begin
                        if (r_phase == PH_FIRST) begin
                            ram_re = 1'b1;
                        end else begin
                            ram_re   = credit_ok;
                            ram_addr = r_s2_addr_hi;
                            s2_done  = credit_ok;
                        end
                    end
                    default: ;
                endcase
                tok_issue = s2_done;
            end
        end
    end

    tlr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_s2_sample),
        .o_rdata (ram_rdata)
    );

    // The floor row sample stays on the read port through any stall, so it is
    // captured on every cycle of the second phase.
    logic [SAMPLE_W-1:0] r_lo;

    always_ff @(posedge i_clk) begin
        if (is_linear && (r_phase == PH_SECOND)) begin
            r_lo <= ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Token stage: the resample whose reads just finished.
    // ------------------------------------------------------------------
    logic                 r_tok_valid;
    t_kind                r_tok_kind;
    logic [FRAC_BITS-1:0] r_tok_frac;
    logic                 r_tok_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= tok_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_issue) begin
            r_tok_kind  <= r_s2_kind;
            r_tok_frac  <= r_s2_frac;
            r_tok_clamp <= r_s2_clamp;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: floor sample and the difference to the ceiling sample.
    // ------------------------------------------------------------------
    logic                     r_b_valid;
    logic signed [SAMPLE_W-1:0] r_b_lo;
    logic signed [DF_W-1:0]   r_b_diff;
    logic [FRAC_BITS-1:0]     r_b_frac;
    logic                     r_b_clamp;
    logic signed [SAMPLE_W-1:0] n_b_lo;
    logic signed [DF_W-1:0]   n_b_diff;
    logic [FRAC_BITS-1:0]     n_b_frac;

    always_comb begin
        n_b_lo   = '0;
        n_b_diff = '0;
        n_b_frac = '0;
        case (r_tok_kind)
            KIND_NEAREST: begin
                n_b_lo = $signed(ram_rdata);
            end
            KIND_LINEAR: begin
                n_b_lo   = $signed(r_lo);
                n_b_diff = $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                         - $signed({r_lo[SAMPLE_W-1], r_lo});
                n_b_frac = r_tok_frac;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_tok_valid) begin
            r_b_lo    <= n_b_lo;
            r_b_diff  <= n_b_diff;
            r_b_frac  <= n_b_frac;
            r_b_clamp <= r_tok_clamp;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: difference times fraction.
    // ------------------------------------------------------------------
    logic                       r_c_valid;
    logic signed [SAMPLE_W-1:0] r_c_lo;
    logic signed [PW-1:0]       r_c_prod;
    logic                       r_c_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_lo    <= r_b_lo;
            r_c_prod  <= PW'(r_b_diff) * PW'($signed({1'b0, r_b_frac}));
            r_c_clamp <= r_b_clamp;
        end
    end

    // Rounded blend in one sum: floor((lo * 2^F + diff * frac + half) / 2^F).
    // The value lies between the two samples, so the slice never overflows.
    logic signed [SW-1:0] c_sum;
    t_out_item            c_result;

    always_comb begin
        c_sum = (SW'(r_c_lo) <<< FRAC_BITS) + SW'(r_c_prod) + HALF;
        c_result.result_value  = c_sum[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
        c_result.index_clamped = r_c_clamp;
    end

    // ------------------------------------------------------------------
    // Result queue. The in-flight count covers the token stage, stages B
    // and C and the queue, so the queue cannot overflow.
    // ------------------------------------------------------------------
    t_out_item       r_fifo [FD];
    logic [FP_W-1:0] r_wptr;
    logic [FP_W-1:0] r_rptr;
    logic [FC_W-1:0] r_fcount;
    logic            pop;

    assign o_out.valid = r_fcount != '0;
    assign o_out.data  = r_fifo[r_rptr];
    assign pop         = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_fcount   <= '0;
            r_inflight <= '0;
        end else begin
            if (r_c_valid) begin
                r_wptr <= r_wptr + FP_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FP_W'(1);
            end
            r_fcount   <= r_fcount + FC_W'(r_c_valid) - FC_W'(pop);
            r_inflight <= r_inflight + FC_W'(tok_issue) - FC_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_fifo[r_wptr] <= c_result;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tlr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== test/tlr_resample_checker.sv =====
`timescale 1ns / 1ps

// Watches both item channels and the configuration port, keeps its own copy of the
// trajectory store and the registers, and compares every result with its prediction.
module tlr_resample_checker import tlr_pkg::*; #(
    parameter int MAX_STEPS = 1024,
    parameter int MAX_DIMS  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    tlr_in_if                      i_in_mon,
    tlr_out_if                     i_out_mon,
    output int                     o_mismatches,
    output int                     o_pending
);

    localparam int PRINT_LIMIT = 100;

    logic [SAMPLE_W-1:0] samples [MAX_STEPS*MAX_DIMS];
    logic [LEN_W-1:0]    length_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic                nearest_reg;

    t_out_item expected_results [$];
    int        mismatch_count = 0;
    int        result_count   = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t mismatch at result %0d: %s", $realtime, result_count, what);
        end
        mismatch_count++;
    endtask

    function automatic longint stored_sample(input longint unsigned row,
                                             input logic [DIM_W-1:0] dim);
        logic signed [SAMPLE_W-1:0] s;
        s = samples[row * MAX_DIMS + dim];
        return s;
    endfunction

    function automatic t_out_item resample_value(input logic [ROW_W-1:0] row,
                                                 input logic [DIM_W-1:0] dim);
        t_out_item       res;
        longint unsigned span;
        longint unsigned last_row;
        longint unsigned position;
        longint unsigned lo_row;
        longint unsigned hi_row;
        longint unsigned frac;
        longint          lo_val;
        longint          hi_val;
        longint          blend;
        res = '0;
        if (dim >= MAX_DIMS) begin
            return res;
        end
        span = (length_reg == 0) ? 1 : length_reg;
        if (span > MAX_STEPS) begin
            span = MAX_STEPS;
        end
        last_row = span - 1;
        position = row;
        position = position * ratio_reg;
        lo_row   = position >> FRAC_BITS;
        frac     = position & ((64'd1 << FRAC_BITS) - 1);
        if (lo_row > last_row) begin
            lo_row            = last_row;
            frac              = 0;
            res.index_clamped = 1'b1;
        end
        lo_val = stored_sample(lo_row, dim);
        if (nearest_reg) begin
            blend = lo_val;
        end else begin
            hi_row = lo_row + ((frac != 0) ? 1 : 0);
            if (hi_row > last_row) begin
                hi_row = last_row;
            end
            hi_val = stored_sample(hi_row, dim);
            // Round half up, then floor toward minus infinity via arithmetic shift.
            blend = lo_val + (((hi_val - lo_val) * longint'(frac)
                               + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        end
        res.result_value = blend[SAMPLE_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        t_in_item  item;
        if (!i_rst_n) begin
            length_reg  <= LEN_W'(1);
            ratio_reg   <= RATIO_RESET;
            nearest_reg <= 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INPUT_LENGTH: length_reg  <= i_cfg_data[LEN_W-1:0];
                    CFG_INDEX_RATIO:  ratio_reg   <= i_cfg_data[RATIO_W-1:0];
                    CFG_NEAREST_MODE: nearest_reg <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Results are retired before new work is queued, so a result that shows
            // up with nothing outstanding is never matched to a same-cycle request.
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.data;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %h clamped %b",
                                              got.result_value, got.index_clamped));
                end else begin
                    want = expected_results.pop_front();
                    if (got.result_value !== want.result_value) begin
                        report_mismatch($sformatf("result_value %h, predicted %h",
                                                  got.result_value, want.result_value));
                    end
                    if (got.index_clamped !== want.index_clamped) begin
                        report_mismatch($sformatf("index_clamped %b, predicted %b",
                                                  got.index_clamped, want.index_clamped));
                    end
                end
                result_count++;
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                item = i_in_mon.data;
                if (item.command == CMD_LOAD) begin
                    if (item.row_index < MAX_STEPS && item.dim_index < MAX_DIMS) begin
                        samples[item.row_index * MAX_DIMS + item.dim_index] =
                            item.sample_value;
                    end
                end else begin
                    expected_results.push_back(resample_value(item.row_index,
                                                              item.dim_index));
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the trajectory resampler. The top only produces stimulus and the
// verdict: a checker instance beside the block predicts every resample result from
// its own copy of the store and the registers, and compares the results in order.
//
// The run starts with a short directed part (reset settings, sample extremes, a
// half-step ratio that forces both the ceiling clamp and the floor clamp, and
// nearest mode), then goes through a series of random phases. Each phase programs
// all three registers while the block is idle, makes sure every row that a resample
// may read has been loaded, and then mixes loads and resamples.
module tb;
    import tlr_pkg::*;

    localparam int STORE_ROWS    = 1024;
    localparam int STORE_DIMS    = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 20;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    tlr_in_if  in_ch ();
    tlr_out_if out_ch ();

    int              mismatches;
    int              pending;
    bit              idle_on = 1'b1;
    int unsigned     ready_hold = 0;
    longint unsigned cycles = 0;

    // Which store entries have been written. The prefix count per dimension tells
    // how many rows from row zero upward are known, so a resample never reads an
    // entry that was never loaded.
    bit              loaded [STORE_ROWS][STORE_DIMS];
    int              loaded_prefix [STORE_DIMS];

    always #4 i_clk = ~i_clk;

    trajectory_linear_resampler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    tlr_resample_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // A hung block or a result that never arrives ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[trajectory_linear_resampler_unit] ERROR");
            $finish;
        end
    end

    // The receiver stalls in bursts of random length while idling is enabled.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            out_ch.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 7);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Drives one item and returns at the edge where its transfer happens. The
    // sender sometimes drops valid for a burst first; otherwise the next item
    // follows back to back.
    task automatic send_item(input logic cmd, input logic [ROW_W-1:0] row,
                             input logic [DIM_W-1:0] dim, input logic [SAMPLE_W-1:0] value);
        t_in_item item;
        int       gap;
        item.command      = cmd;
        item.row_index    = row;
        item.dim_index    = dim;
        item.sample_value = value;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic load_sample(input int row, input int dim, input logic [SAMPLE_W-1:0] value);
        send_item(CMD_LOAD, row[ROW_W-1:0], dim[DIM_W-1:0], value);
        loaded[row][dim] = 1'b1;
        while (loaded_prefix[dim] < STORE_ROWS && loaded[loaded_prefix[dim]][dim]) begin
            loaded_prefix[dim]++;
        end
    endtask

    // The sample field of a resample is ignored by the block, but it still gets
    // random content so that every bit of the channel toggles.
    task automatic resample(input int row, input int dim);
        send_item(CMD_RESAMPLE, row[ROW_W-1:0], dim[DIM_W-1:0], $urandom());
    endtask

    // Waits until every predicted result has arrived, then lets a load that is
    // still on its way through the block finish before anything else happens.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int len, input logic [RATIO_W-1:0] ratio,
                              input logic nearest);
        quiesce();
        write_register(CFG_INPUT_LENGTH, CFG_DATA_W'(len));
        write_register(CFG_INDEX_RATIO, CFG_DATA_W'(ratio));
        write_register(CFG_NEAREST_MODE, CFG_DATA_W'(nearest));
        i_cfg_we <= 1'b0;
    endtask

    // Rows that the block actually uses for a given length register value.
    function automatic int effective_rows(input int len);
        if (len == 0) begin
            return 1;
        end
        return (len > STORE_ROWS) ? STORE_ROWS : len;
    endfunction

    task automatic fill_rows(input int dim, input int rows);
        while (loaded_prefix[dim] < rows) begin
            load_sample(loaded_prefix[dim], dim, $urandom());
        end
    endtask

    // Sample values lean toward the signed extremes, where the blend difference
    // is widest.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return SAMPLE_W'(int'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000);
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int                 len;
        int                 rows;
        int                 big_dim;
        int                 dims [2];
        int                 dim;
        longint             reach;
        logic [RATIO_W-1:0] ratio;
        logic               nearest;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_INPUT_LENGTH;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        foreach (loaded_prefix[d]) loaded_prefix[d] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one row, unit ratio, linear. Row two lies past the
        // only row and must come back clamped.
        load_sample(0, 0, 32'h0001_8000);
        resample(0, 0);
        resample(2, 0);

        // Four rows with a half-row step. Output row seven lands halfway between
        // the last row and a ceiling that does not exist; output row eight and
        // the top output row fall past the last row.
        set_config(4, 26'h0_8000, 1'b0);
        load_sample(0, 0, 32'h7FFF_FFFF);
        load_sample(1, 0, 32'h8000_0000);
        load_sample(2, 0, 32'h0000_0000);
        load_sample(3, 0, 32'hFFFF_FFFF);
        load_sample(0, 7, 32'h0001_0000);
        load_sample(1, 7, 32'hFFFF_0000);
        load_sample(2, 7, 32'h0000_8000);
        load_sample(3, 7, 32'h1234_5678);
        load_sample(1023, 7, $urandom());
        for (int r = 0; r <= 8; r++) begin
            resample(r, 0);
        end
        resample(1023, 7);

        // Nearest mode with a step of one and a half rows.
        set_config(4, 26'h1_8000, 1'b1);
        resample(1, 7);
        resample(2, 7);
        resample(1023, 7);

        // Random phases. The first few pin the length and ratio extremes; the
        // long store is loaded in full once, in one dimension, and reused.
        big_dim = $urandom_range(0, STORE_DIMS - 1);
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       len = 0;
                1:       len = 2047;
                2:       len = 1024;
                3:       len = 1025;
                4:       len = 2;
                default: len = $urandom_range(1, 40);
            endcase
            rows = effective_rows(len);
            case (p)
                0: ratio = '0;
                1: ratio = 26'h3FF_FFFF;
                2: ratio = RATIO_W'(((rows - 1) << 16) / 511);
                3: ratio = RATIO_RESET;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       ratio = '0;
                        1:       ratio = 26'h3FF_FFFF;
                        2:       ratio = RATIO_RESET;
                        3:       ratio = RATIO_W'(((rows - 1) << 16) / $urandom_range(1, 199));
                        4:       ratio = RATIO_W'($urandom_range(1, 65535));
                        default: ratio = RATIO_W'($urandom());
                    endcase
                end
            endcase
            nearest = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'(($urandom_range(0, 2) == 0));

            // Some phases run without idling on either side, and the last two
            // never idle.
            idle_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);

            set_config(len, ratio, nearest);

            if (rows > 64) begin
                dims[0] = big_dim;
                dims[1] = big_dim;
            end else begin
                dims[0] = $urandom_range(0, STORE_DIMS - 1);
                dims[1] = $urandom_range(0, STORE_DIMS - 1);
            end
            fill_rows(dims[0], rows);
            fill_rows(dims[1], rows);

            // Output rows up to one past the last in-range position are favored,
            // so the floor clamp boundary is hit often without wasting items.
            reach = (ratio == 0) ? 1023 : ((longint'(rows) - 1) * 65536) / ratio + 1;
            if (reach > 1023) begin
                reach = 1023;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 35) begin
                    if ($urandom_range(0, 9) < 7) begin
                        load_sample($urandom_range(0, rows - 1), dims[$urandom_range(0, 1)],
                                    pick_sample());
                    end else begin
                        load_sample($urandom_range(0, STORE_ROWS - 1),
                                    $urandom_range(0, STORE_DIMS - 1), pick_sample());
                    end
                end else begin
                    dim = dims[$urandom_range(0, 1)];
                    if ($urandom_range(0, 9) < 7) begin
                        resample($urandom_range(0, int'(reach)), dim);
                    end else begin
                        resample($urandom_range(0, STORE_ROWS - 1), dim);
                    end
                end
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("[trajectory_linear_resampler_unit] OK");
        end else begin
            $display("[trajectory_linear_resampler_unit] ERROR");
        end
        $finish;
    end

endmodule
